// ===== hdl/scba_pkg.sv =====
// ----------------------------------------------------------------------------
// scba_pkg
// Shared constants, class table and controller/datapath types for the
// size-class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

   localparam int NUM_CLASSES   = 36;
   localparam int CHUNK_BYTES   = 4096;
   localparam int MAX_CHUNKS    = 64;
   localparam int LARGEST_BLOCK = 1024;

   localparam int TABLE_LEN  = 36;
   localparam int ADDR_W     = 18;
   localparam int SIZE_W     = 16;
   localparam int WORD_SHIFT = 3;
   localparam int IDX_W      = ADDR_W - WORD_SHIFT;
   localparam int LINK_W     = IDX_W + 1;
   localparam int LINK_DEPTH = 1 << IDX_W;
   localparam int BYTES_W    = 11;
   localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CNT_W      = $clog2(MAX_CHUNKS + 1);
   localparam int WALK_W     = ADDR_W + 1;
   localparam int ADDR_SPACE = 1 << ADDR_W;

   localparam logic [BYTES_W-1:0] CLASS_BYTES [TABLE_LEN] = '{
      11'd8,   11'd16,  11'd32,  11'd48,  11'd64,  11'd96,  11'd128, 11'd144,
      11'd160, 11'd176, 11'd192, 11'd224, 11'd256, 11'd288, 11'd320, 11'd352,
      11'd384, 11'd416, 11'd480, 11'd512, 11'd544, 11'd576, 11'd608, 11'd640,
      11'd672, 11'd704, 11'd736, 11'd768, 11'd800, 11'd832, 11'd864, 11'd896,
      11'd928, 11'd960, 11'd992, 11'd1024
   };

   typedef logic [1:0] status_type;
   localparam status_type ST_DONE      = 2'd0;
   localparam status_type ST_ZERO      = 2'd1;
   localparam status_type ST_OVERSIZE  = 2'd2;
   localparam status_type ST_EXHAUSTED = 2'd3;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef struct packed {
      logic       capture;
      logic       push;
      logic       pop_rd;
      logic       pop_wr;
      logic       claim;
      logic       carve;
      logic       rsp_en;
      status_type rsp_code;
   } scba_cmd_type;

   typedef struct packed {
      logic is_zero;
      logic is_over;
      logic is_free;
      logic head_valid;
      logic exhausted;
      logic carve_last;
   } scba_stat_type;

endpackage

// ===== hdl/scba_ram.sv =====
// ----------------------------------------------------------------------------
// scba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/scba_ctrl.sv =====
// ----------------------------------------------------------------------------
// scba_ctrl
// Sequencer: accept, execute, pop completion and chunk carve walk.
// ----------------------------------------------------------------------------
module scba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  scba_pkg::scba_stat_type stat,
   output scba_pkg::scba_cmd_type  cmd
);
   import scba_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_POP   = 2'd2;
   localparam logic [1:0] S_CARVE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rsp_code = ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_IDLE;
            priority if (stat.is_zero) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_code = ST_ZERO;
            end else if (stat.is_over) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_code = ST_OVERSIZE;
            end else if (stat.is_free) begin
               cmd.push   = 1'b1;
               cmd.rsp_en = 1'b1;
            end else if (stat.head_valid) begin
               cmd.pop_rd = 1'b1;
               state_in   = S_POP;
            end else if (stat.exhausted) begin
               cmd.rsp_en   = 1'b1;
               cmd.rsp_code = ST_EXHAUSTED;
            end else begin
               cmd.claim = 1'b1;
               state_in  = S_CARVE;
            end
         end
         S_POP: begin
            cmd.pop_wr = 1'b1;
            cmd.rsp_en = 1'b1;
            state_in   = S_IDLE;
         end
         S_CARVE: begin
            cmd.carve = 1'b1;
            if (stat.carve_last) begin
               cmd.rsp_en = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== hdl/scba_datapath.sv =====
// ----------------------------------------------------------------------------
// scba_datapath
// Class lookup, free-list heads, chunk pool counters, link store and the
// result register.
// ----------------------------------------------------------------------------
module scba_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  scba_pkg::scba_cmd_type        cmd,
   output scba_pkg::scba_stat_type       stat,
   input  logic                          req_command,
   input  logic [scba_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [scba_pkg::ADDR_W-1:0]   req_block_address,
   output logic                          rsp_valid,
   output logic [scba_pkg::ADDR_W-1:0]   rsp_granted_address,
   output scba_pkg::status_type          rsp_status
);
   import scba_pkg::*;

   localparam logic [WALK_W-1:0] CHUNK_SZ = WALK_W'(CHUNK_BYTES);
   localparam logic [WALK_W-1:0] SPACE_SZ = WALK_W'(ADDR_SPACE);

   // captured request
   logic              free_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [CLS_W-1:0]  cls_ff;
   logic              zero_ff;
   logic              over_ff;

   logic [CLS_W-1:0]  cls_in;
   logic              found;

   // list heads (index in RAM, valid bits in flops) and pool state
   logic [NUM_CLASSES-1:0] head_vld_ff, head_vld_in;
   logic                   head_we;
   logic [LINK_W-1:0]      head_wdata;
   logic [CLS_W-1:0]       head_raddr;
   logic [IDX_W-1:0]       head_rdata;
   logic [CNT_W-1:0]  chunks_ff, chunks_in;
   logic [WALK_W-1:0] base_ff, base_in;

   // carve walk
   logic [WALK_W-1:0] walk_ff, walk_in;
   logic [WALK_W-1:0] end_ff, end_in;
   logic [WALK_W-1:0] start_ff, start_in;

   // result
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   status_type        rsp_status_ff;

   logic [LINK_W-1:0] cur_head;
   logic [WALK_W-1:0] bs;
   logic [WALK_W-1:0] first_next;
   logic              two_fit;
   logic [WALK_W-1:0] walk_next;
   logic              walk_last;
   logic [LINK_W-1:0] carve_link;

   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   logic [LINK_W-1:0] ram_wdata;
   logic [LINK_W-1:0] ram_rdata;

   // smallest fitting class
   always_comb begin
      cls_in = '0;
      found  = 1'b0;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if ({5'd0, CLASS_BYTES[i]} >= req_request_size) begin
            cls_in = CLS_W'(i);
            found  = 1'b1;
         end
      end
   end

   // head read is issued on the accepting edge so it is ready in execute
   assign head_raddr = cmd.capture ? cls_in : cls_ff;
   assign cur_head   = head_vld_ff[cls_ff] ? {1'b1, head_rdata} : '0;
   assign bs         = WALK_W'(CLASS_BYTES[cls_ff]);
   assign first_next = base_ff + bs;
   assign two_fit    = (first_next + bs) <= (base_ff + CHUNK_SZ);
   assign walk_next  = walk_ff + bs;
   assign walk_last  = (walk_next + bs) > end_ff;
   assign carve_link = walk_last ? '0 : {1'b1, walk_next[ADDR_W-1:WORD_SHIFT]};

   always_comb begin
      stat.is_zero    = zero_ff;
      stat.is_over    = over_ff;
      stat.is_free    = (free_ff == CMD_FREE);
      stat.head_valid = cur_head[LINK_W-1];
      stat.exhausted  = (chunks_ff >= CNT_W'(MAX_CHUNKS)) ||
                        ((base_ff + CHUNK_SZ) > SPACE_SZ);
      stat.carve_last = walk_last;
   end

   always_comb begin
      head_we    = 1'b0;
      head_wdata = '0;
      chunks_in  = chunks_ff;
      base_in    = base_ff;
      walk_in    = walk_ff;
      end_in     = end_ff;
      start_in   = start_ff;
      if (cmd.push) begin
         head_we    = 1'b1;
         head_wdata = {1'b1, addr_ff[ADDR_W-1:WORD_SHIFT]};
      end
      if (cmd.pop_wr) begin
         head_we    = 1'b1;
         head_wdata = ram_rdata;
      end
      if (cmd.claim) begin
         head_we    = 1'b1;
         head_wdata = two_fit ? {1'b1, first_next[ADDR_W-1:WORD_SHIFT]} : '0;
         chunks_in  = chunks_ff + CNT_W'(1);
         base_in    = base_ff + CHUNK_SZ;
         walk_in    = base_ff;
         end_in     = base_ff + CHUNK_SZ;
         start_in   = base_ff;
      end
      if (cmd.carve) begin
         walk_in = walk_next;
      end
   end

   always_comb begin
      head_vld_in = head_vld_ff;
      if (head_we) begin
         head_vld_in[cls_ff] = head_wdata[LINK_W-1];
      end
   end

   always_comb begin
      ram_we    = cmd.push | cmd.carve;
      ram_waddr = cmd.carve ? walk_ff[ADDR_W-1:WORD_SHIFT] : addr_ff[ADDR_W-1:WORD_SHIFT];
      ram_wdata = cmd.carve ? carve_link : cur_head;
   end

   always_comb begin
      if (cmd.pop_wr) begin
         rsp_addr_in = {cur_head[IDX_W-1:0], {WORD_SHIFT{1'b0}}};
      end else if (cmd.carve) begin
         rsp_addr_in = start_ff[ADDR_W-1:0];
      end else begin
         rsp_addr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff  <= '0;
         chunks_ff    <= '0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_vld_ff  <= head_vld_in;
         chunks_ff    <= chunks_in;
         base_ff      <= base_in;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         free_ff <= req_command;
         addr_ff <= req_block_address;
         cls_ff  <= cls_in;
         zero_ff <= (req_request_size == '0);
         over_ff <= (req_request_size > SIZE_W'(LARGEST_BLOCK)) || !found;
      end
      walk_ff  <= walk_in;
      end_ff   <= end_in;
      start_ff <= start_in;
      if (cmd.rsp_en) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= cmd.rsp_code;
      end
   end

   scba_ram #(
      .WIDTH (IDX_W),
      .DEPTH (NUM_CLASSES)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (cls_ff),
      .wr_data (head_wdata[IDX_W-1:0]),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   scba_ram #(
      .WIDTH (LINK_W),
      .DEPTH (LINK_DEPTH)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cur_head[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;

endmodule

// ===== hdl/size_class_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// Segregated free-list allocator: 36 block-size classes, free lists linked
// through a word-indexed link RAM, fresh chunks carved from a fixed pool.
//
//   channel  ports                                        transfer when
//   req      req_command, req_request_size,
//            req_block_address                            start & !busy
//   rsp      rsp_granted_address, rsp_status              rsp_valid
//
// Zero size, oversize, exhausted pool and free: answered from the execute state.
// Allocate from a non-empty list: execute, then pop (one link RAM read).
// Allocate that carves a chunk: execute claims the chunk, then the carve
// state walks it with one link RAM write per block.
// Synchronous reset empties every list; the link RAM is not cleared.
// rsp_valid is high for one cycle only; the receiver cannot stall.
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [scba_pkg::SIZE_W-1:0]   req_request_size,
   input  logic [scba_pkg::ADDR_W-1:0]   req_block_address,
   output logic                          rsp_valid,
   output logic [scba_pkg::ADDR_W-1:0]   rsp_granted_address,
   output logic [1:0]                    rsp_status
);
   import scba_pkg::*;

   scba_cmd_type  cmd;
   scba_stat_type stat;

   scba_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   scba_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_command         (req_command),
      .req_request_size    (req_request_size),
      .req_block_address   (req_block_address),
      .rsp_valid           (rsp_valid),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status)
   );

endmodule
